// File: rtl/core/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, register indexes, event codes and the CRC-16 byte update
// for the framed CRC-16 deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam logic [7:0] REG_SYNC_FIRST       = 8'd0;
    localparam logic [7:0] REG_SYNC_SECOND      = 8'd1;
    localparam logic [7:0] REG_VERSION_EXPECTED = 8'd2;
    localparam logic [7:0] REG_CRC_INIT         = 8'd3;
    localparam logic [7:0] REG_TYPE_CODE_A      = 8'd4;
    localparam logic [7:0] REG_TYPE_CODE_B      = 8'd5;

    // reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RST       = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND_RST      = 8'h5A;
    localparam logic [7:0]  VERSION_EXPECTED_RST = 8'h01;
    localparam logic [15:0] CRC_INIT_RST         = 16'hFFFF;
    localparam logic [7:0]  TYPE_CODE_A_RST      = 8'h01;
    localparam logic [7:0]  TYPE_CODE_B_RST      = 8'h02;

    // frame result codes
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_HDR_REJECT  = 3'd1;
    localparam logic [2:0] EV_CRC_ERROR   = 3'd2;
    localparam logic [2:0] EV_GOOD_KNOWN  = 3'd3;
    localparam logic [2:0] EV_GOOD_UNKNWN = 3'd4;

    localparam logic [10:0] FRAME_LEN_SAT = 11'd2047;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  version_expected;
        logic [15:0] crc_init;
        logic [7:0]  type_code_a;
        logic [7:0]  type_code_b;
    } cfg_t;

    // input register contents handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_req_t;

    // msb-first crc-16 over one byte, eight shift steps unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/sync_framed_crc16_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_framed_crc16_deframer_unit - framed crc-16 packet deframer
// Path from input request to result: input register, then result register.
// Throughput: 1 byte per cycle when out_stall is low; the byte-wide crc
// update and the step sit between the input and result registers
// Reset: async rst_n clears state, counters, config to defaults
// ----------------------------------------------------------------------------
module sync_framed_crc16_deframer_unit
    import sfcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         payload_valid,
    output logic [7:0]   payload_data,
    output logic [9:0]   payload_index,
    output logic [2:0]   frame_event,
    output logic [7:0]   frame_type,
    output logic [10:0]  frame_length,
    output logic [31:0]  good_frame_count,
    output logic [31:0]  crc_error_count,
    output logic [31:0]  bad_frame_count,
    output logic [2:0]   parser_phase
);

    cfg_t    cfg;
    in_req_t req;
    logic    advance;

    sfcd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfcd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .advance   (advance),
        .req       (req)
    );

    sfcd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .req              (req),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .payload_valid    (payload_valid),
        .payload_data     (payload_data),
        .payload_index    (payload_index),
        .frame_event      (frame_event),
        .frame_type       (frame_type),
        .frame_length     (frame_length),
        .good_frame_count (good_frame_count),
        .crc_error_count  (crc_error_count),
        .bad_frame_count  (bad_frame_count),
        .parser_phase     (parser_phase)
    );

endmodule

// File: rtl/core/sfcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfcd_cfg_regs
// Configuration register file: sync bytes, expected version, crc start
// value and the two known type codes.
// ----------------------------------------------------------------------------
module sfcd_cfg_regs
    import sfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:       cfg_next.sync_first       = cfg_data[7:0];
                REG_SYNC_SECOND:      cfg_next.sync_second      = cfg_data[7:0];
                REG_VERSION_EXPECTED: cfg_next.version_expected = cfg_data[7:0];
                REG_CRC_INIT:         cfg_next.crc_init         = cfg_data;
                REG_TYPE_CODE_A:      cfg_next.type_code_a      = cfg_data[7:0];
                REG_TYPE_CODE_B:      cfg_next.type_code_b      = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first       <= SYNC_FIRST_RST;
            cfg_reg.sync_second      <= SYNC_SECOND_RST;
            cfg_reg.version_expected <= VERSION_EXPECTED_RST;
            cfg_reg.crc_init         <= CRC_INIT_RST;
            cfg_reg.type_code_a      <= TYPE_CODE_A_RST;
            cfg_reg.type_code_b      <= TYPE_CODE_B_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/sfcd_in_stage.sv
// ----------------------------------------------------------------------------
// sfcd_in_stage
// Input register for received bytes; holds a request while the parser
// cannot advance.
// ----------------------------------------------------------------------------
module sfcd_in_stage
    import sfcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output in_req_t    req
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign req      = '{valid: valid_reg, data: data_reg};

    // an empty register takes a request even while the result side is stalled
    always_comb
    begin
        valid_next = valid_reg;
        if (advance || !valid_reg)
            valid_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_byte;
    end

endmodule

// File: rtl/core/sfcd_parser.sv
// ----------------------------------------------------------------------------
// sfcd_parser
// Frame state machine: sync hunt, header capture, payload forwarding,
// crc check, frame counters and the result register.
// ----------------------------------------------------------------------------
module sfcd_parser
    import sfcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  in_req_t      req,
    output logic         advance,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         payload_valid,
    output logic [7:0]   payload_data,
    output logic [9:0]   payload_index,
    output logic [2:0]   frame_event,
    output logic [7:0]   frame_type,
    output logic [10:0]  frame_length,
    output logic [31:0]  good_frame_count,
    output logic [31:0]  crc_error_count,
    output logic [31:0]  bad_frame_count,
    output logic [2:0]   parser_phase
);

    localparam int CNT_RAW = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    phase_t            phase_reg,   phase_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [7:0]        ver_reg,     ver_next;
    logic [7:0]        type_reg,    type_next;
    logic [15:0]       len_reg,     len_next;
    logic [15:0]       crc_reg,     crc_next;
    logic [7:0]        crc_lo_reg,  crc_lo_next;
    logic [31:0]       good_reg,    good_next;
    logic [31:0]       crcerr_reg,  crcerr_next;
    logic [31:0]       bad_reg,     bad_next;

    logic              out_valid_reg, out_valid_next;
    logic              pv_reg;
    logic [7:0]        pd_reg;
    logic [9:0]        pi_reg;
    logic [2:0]        ev_reg;

    logic              pv;
    logic [7:0]        pd;
    logic [9:0]        pi;
    logic [2:0]        ev;
    logic              fire;
    logic [7:0]        b;
    logic [15:0]       crc_upd;
    logic [16:0]       cnt_inc;
    logic [15:0]       cnt_ext;
    logic [15:0]       want;

    assign advance = !out_valid_reg || !out_stall;
    assign fire    = req.valid && advance;
    assign b       = req.data;
    assign crc_upd = crc16_byte(crc_reg, b);
    assign cnt_inc = 17'(cnt_reg) + 17'd1;
    assign cnt_ext = 16'(cnt_reg);
    assign want    = {b, crc_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ver_next    = ver_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        good_next   = good_reg;
        crcerr_next = crcerr_reg;
        bad_next    = bad_reg;
        pv          = 1'b0;
        pd          = 8'd0;
        pi          = 10'd0;
        ev          = EV_NONE;

        unique case (phase_reg)
            PH_SYNC2:
            begin
                // sync_second is tested first so equal sync bytes start a frame
                if (b == cfg.sync_second)
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                    ver_next   = 8'd0;
                    type_next  = 8'd0;
                    len_next   = 16'd0;
                    crc_next   = cfg.crc_init;
                end
                else if (b != cfg.sync_first)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_HEADER:
            begin
                crc_next = crc_upd;
                priority if (cnt_reg == CNT_W'(0))
                    ver_next = b;
                else if (cnt_reg == CNT_W'(1))
                    type_next = b;
                else if (cnt_reg == CNT_W'(2))
                    len_next = {len_reg[15:8], b};
                else
                    len_next = {b, len_reg[7:0]};

                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next = '0;
                    if (ver_reg != cfg.version_expected || len_next > MAX_LEN)
                    begin
                        bad_next   = bad_reg + 32'd1;
                        ev         = EV_HDR_REJECT;
                        phase_next = PH_SYNC1;
                    end
                    else if (len_next != 16'd0)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_CRC;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc[CNT_W-1:0];
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_upd;
                pv       = 1'b1;
                pd       = b;
                pi       = cnt_ext[9:0];
                if (cnt_inc >= {1'b0, len_reg})
                begin
                    cnt_next   = '0;
                    phase_next = PH_CRC;
                end
                else
                begin
                    cnt_next = cnt_inc[CNT_W-1:0];
                end
            end
            PH_CRC:
            begin
                if (cnt_reg == CNT_W'(0))
                begin
                    crc_lo_next = b;
                    cnt_next    = CNT_W'(1);
                end
                else
                begin
                    cnt_next   = '0;
                    phase_next = PH_SYNC1;
                    if (want != crc_reg)
                    begin
                        crcerr_next = crcerr_reg + 32'd1;
                        ev          = EV_CRC_ERROR;
                    end
                    else
                    begin
                        good_next = good_reg + 32'd1;
                        if (type_reg == cfg.type_code_a || type_reg == cfg.type_code_b)
                        begin
                            ev = EV_GOOD_KNOWN;
                        end
                        else
                        begin
                            bad_next = bad_reg + 32'd1;
                            ev       = EV_GOOD_UNKNWN;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = (b == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = req.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            cnt_reg       <= '0;
            ver_reg       <= 8'd0;
            type_reg      <= 8'd0;
            len_reg       <= 16'd0;
            crc_reg       <= 16'd0;
            crc_lo_reg    <= 8'd0;
            good_reg      <= 32'd0;
            crcerr_reg    <= 32'd0;
            bad_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                ver_reg    <= ver_next;
                type_reg   <= type_next;
                len_reg    <= len_next;
                crc_reg    <= crc_next;
                crc_lo_reg <= crc_lo_next;
                good_reg   <= good_next;
                crcerr_reg <= crcerr_next;
                bad_reg    <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pv_reg <= pv;
            pd_reg <= pd;
            pi_reg <= pi;
            ev_reg <= ev;
        end
    end

    // frame state only moves with a request, so it doubles as result fields
    assign out_valid        = out_valid_reg;
    assign payload_valid    = pv_reg;
    assign payload_data     = pd_reg;
    assign payload_index    = pi_reg;
    assign frame_event      = ev_reg;
    assign frame_type       = type_reg;
    assign frame_length     = (len_reg > 16'(FRAME_LEN_SAT)) ? FRAME_LEN_SAT : len_reg[10:0];
    assign good_frame_count = good_reg;
    assign crc_error_count  = crcerr_reg;
    assign bad_frame_count  = bad_reg;
    assign parser_phase     = phase_reg;

endmodule
